// ===== hdl/sdba_pkg.sv =====
package sdba_pkg;

  // Scan and alignment limits
  localparam int TAP_COUNT  = 32;
  localparam int SLIP_LIMIT = 4;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int TAP_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 12;
  localparam int SLIP_W  = 4;
  localparam int ACT_W   = 2;
  localparam int CFG_IDX_W = 2;

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = 4;

  // Register reset values
  localparam logic [WORD_W-1:0] PATTERN_RST  = 32'hFFAA5500;
  localparam logic [TAP_W-1:0]  MIN_RUN_RST  = 6'd4;
  localparam logic [TAP_W-1:0]  FALLBACK_RST = 6'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 2'd2;

  // Input item kinds
  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_READBACK = 1'b1;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_TAP  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SLIP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DONE = 2'd2;

  // Training phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_SLIP
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    C_WAIT,
    C_DIV,
    C_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } sdba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
    logic need_div;
    logic div_last;
    logic out_free;
  } sdba_sts_t;

endpackage

// ===== hdl/sdba_req_if.sv =====
interface sdba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [sdba_pkg::WORD_W-1:0] readback_word;

  modport source (output valid, output kind, output readback_word, input ready);
  modport sink   (input valid, input kind, input readback_word, output ready);
endinterface

// ===== hdl/sdba_rsp_if.sv =====
interface sdba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sdba_pkg::ACT_W-1:0]  action;
  logic [sdba_pkg::TAP_W-1:0]  tap;
  logic [sdba_pkg::SLIP_W-1:0] slips;
  logic                        aligned;

  modport source (output valid, output action, output tap, output slips, output aligned,
                  input ready);
  modport sink   (input valid, input action, input tap, input slips, input aligned,
                  output ready);
endinterface

// ===== hdl/sdba_ctrl.sv =====
module sdba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdba_pkg::sdba_sts_t sts,
  output sdba_pkg::sdba_cmd_t cmd
);

  sdba_pkg::ctrl_state_t state;
  sdba_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdba_pkg::C_WAIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sdba_pkg::C_WAIT: begin
        if (in_valid) begin
          if (sts.need_div) begin
            state_next = sdba_pkg::C_DIV;
          end else if (sts.has_result) begin
            state_next = sdba_pkg::C_EMIT;
          end
        end
      end
      sdba_pkg::C_DIV: begin
        if (sts.div_last) begin
          state_next = sdba_pkg::C_EMIT;
        end
      end
      sdba_pkg::C_EMIT: begin
        if (sts.out_free) begin
          state_next = sdba_pkg::C_WAIT;
        end
      end
      default: state_next = sdba_pkg::C_WAIT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      sdba_pkg::C_WAIT: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sdba_pkg::C_DIV: begin
        cmd.div_step = 1'b1;
      end
      sdba_pkg::C_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/sdba_dp.sv =====
module sdba_dp (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [sdba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdba_pkg::WORD_W-1:0]    cfg_data,
  // input payload
  input  logic                           kind,
  input  logic [sdba_pkg::WORD_W-1:0]    readback_word,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sdba_pkg::ACT_W-1:0]     action,
  output logic [sdba_pkg::TAP_W-1:0]     tap,
  output logic [sdba_pkg::SLIP_W-1:0]    slips,
  output logic                           aligned,
  // control
  input  sdba_pkg::sdba_cmd_t            cmd,
  output sdba_pkg::sdba_sts_t            sts
);

  // Configuration registers
  logic [sdba_pkg::WORD_W-1:0] training_pattern;
  logic [sdba_pkg::TAP_W-1:0]  min_run;
  logic [sdba_pkg::TAP_W-1:0]  fallback_tap;

  // Training state
  sdba_pkg::phase_t            phase, phase_next;
  logic [sdba_pkg::TAP_W-1:0]  current_tap, current_tap_next;
  logic [sdba_pkg::CNT_W-1:0]  pass_count, pass_count_next;
  logic [sdba_pkg::SUM_W-1:0]  pass_sum, pass_sum_next;
  logic                        window_open, window_open_next;
  logic [sdba_pkg::TAP_W-1:0]  chosen_tap, chosen_tap_next;
  logic [sdba_pkg::SLIP_W-1:0] slip_index, slip_index_next;

  // Pending result
  logic [sdba_pkg::ACT_W-1:0]  res_action, res_action_next;
  logic [sdba_pkg::TAP_W-1:0]  res_tap, res_tap_next;
  logic [sdba_pkg::SLIP_W-1:0] res_slips, res_slips_next;
  logic                        res_aligned, res_aligned_next;

  // Divider
  logic [sdba_pkg::CNT_W-1:0]     div_rem;
  logic [sdba_pkg::SUM_W-1:0]     div_quo;
  logic [sdba_pkg::CNT_W-1:0]     div_dvs;
  logic [sdba_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [sdba_pkg::CNT_W:0]       div_trial;
  logic                           div_ge;
  logic [sdba_pkg::SUM_W-1:0]     div_quo_step;

  logic                        pass_match;
  logic                        end_scan;
  logic [sdba_pkg::CNT_W-1:0]  tap_inc;
  logic [sdba_pkg::CNT_W-1:0]  cnt_n;
  logic [sdba_pkg::SUM_W-1:0]  sum_n;
  logic [sdba_pkg::SLIP_W:0]   slip_inc;

  // Status bits
  logic                        has_result;
  logic                        need_div;
  logic                        div_last;
  logic                        out_free;

  assign sts = '{has_result: has_result, need_div: need_div,
                 div_last: div_last, out_free: out_free};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      training_pattern <= sdba_pkg::PATTERN_RST;
      min_run          <= sdba_pkg::MIN_RUN_RST;
      fallback_tap     <= sdba_pkg::FALLBACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdba_pkg::CFG_PATTERN:  training_pattern <= cfg_data;
        sdba_pkg::CFG_MIN_RUN:  min_run <= cfg_data[sdba_pkg::TAP_W-1:0];
        sdba_pkg::CFG_FALLBACK: fallback_tap <= cfg_data[sdba_pkg::TAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pattern or any byte rotation of it
  assign pass_match = (readback_word == training_pattern) ||
                      (readback_word == {training_pattern[23:0], training_pattern[31:24]}) ||
                      (readback_word == {training_pattern[15:0], training_pattern[31:16]}) ||
                      (readback_word == {training_pattern[7:0], training_pattern[31:8]});

  assign tap_inc  = {1'b0, current_tap} + 7'd1;
  assign slip_inc = {1'b0, slip_index} + 5'd1;

  // Item decode: next training state and pending result
  always_comb begin
    phase_next       = phase;
    current_tap_next = current_tap;
    pass_count_next  = pass_count;
    pass_sum_next    = pass_sum;
    window_open_next = window_open;
    chosen_tap_next  = chosen_tap;
    slip_index_next  = slip_index;
    res_action_next  = res_action;
    res_tap_next     = res_tap;
    res_slips_next   = res_slips;
    res_aligned_next = res_aligned;
    has_result       = 1'b0;
    need_div         = 1'b0;
    end_scan         = 1'b0;
    cnt_n            = pass_count;
    sum_n            = pass_sum;

    if (kind == sdba_pkg::KIND_START) begin
      phase_next       = sdba_pkg::PH_SCAN;
      current_tap_next = '0;
      pass_count_next  = '0;
      pass_sum_next    = '0;
      window_open_next = 1'b0;
      chosen_tap_next  = '0;
      slip_index_next  = '0;
      res_action_next  = sdba_pkg::ACT_TAP;
      res_tap_next     = '0;
      res_slips_next   = '0;
      res_aligned_next = 1'b0;
      has_result       = 1'b1;
    end else begin
      case (phase)
        sdba_pkg::PH_SCAN: begin
          // run bookkeeping
          if (pass_match) begin
            cnt_n = pass_count + 7'd1;
            sum_n = pass_sum + {6'd0, current_tap};
            if (cnt_n > {1'b0, min_run}) begin
              window_open_next = 1'b1;
            end
          end else if (window_open) begin
            end_scan = 1'b1;
          end else begin
            cnt_n = '0;
            sum_n = '0;
          end
          pass_count_next  = cnt_n;
          pass_sum_next    = sum_n;
          res_action_next  = sdba_pkg::ACT_TAP;
          res_slips_next   = '0;
          res_aligned_next = 1'b0;
          has_result       = 1'b1;
          // step to next tap
          if (!end_scan) begin
            if (tap_inc >= 7'(sdba_pkg::TAP_COUNT)) begin
              end_scan = 1'b1;
            end else begin
              current_tap_next = tap_inc[sdba_pkg::TAP_W-1:0];
              res_tap_next     = tap_inc[sdba_pkg::TAP_W-1:0];
            end
          end
          // scan over: average or fallback
          if (end_scan) begin
            slip_index_next = '0;
            phase_next      = sdba_pkg::PH_SLIP;
            if (cnt_n != '0) begin
              need_div = 1'b1;
            end else begin
              chosen_tap_next = fallback_tap;
              res_tap_next    = fallback_tap;
            end
          end
        end
        sdba_pkg::PH_SLIP: begin
          has_result   = 1'b1;
          res_tap_next = chosen_tap;
          if (readback_word == training_pattern) begin
            phase_next       = sdba_pkg::PH_IDLE;
            res_action_next  = sdba_pkg::ACT_DONE;
            res_slips_next   = slip_index;
            res_aligned_next = 1'b1;
          end else if (slip_inc < 5'(sdba_pkg::SLIP_LIMIT) && slip_index != 4'd15) begin
            slip_index_next  = slip_inc[sdba_pkg::SLIP_W-1:0];
            res_action_next  = sdba_pkg::ACT_SLIP;
            res_slips_next   = '0;
            res_aligned_next = 1'b0;
          end else begin
            phase_next       = sdba_pkg::PH_IDLE;
            res_action_next  = sdba_pkg::ACT_DONE;
            res_slips_next   = '0;
            res_aligned_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Training state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sdba_pkg::PH_IDLE;
      current_tap <= '0;
      pass_count  <= '0;
      pass_sum    <= '0;
      window_open <= 1'b0;
      chosen_tap  <= '0;
      slip_index  <= '0;
    end else if (cmd.accept) begin
      phase       <= phase_next;
      current_tap <= current_tap_next;
      pass_count  <= pass_count_next;
      pass_sum    <= pass_sum_next;
      window_open <= window_open_next;
      chosen_tap  <= chosen_tap_next;
      slip_index  <= slip_index_next;
    end else if (cmd.div_step && div_last) begin
      chosen_tap  <= div_quo_step[sdba_pkg::TAP_W-1:0];
    end
  end

  // Restoring divide step
  assign div_trial    = {div_rem, div_quo[sdba_pkg::SUM_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_dvs};
  assign div_quo_step = {div_quo[sdba_pkg::SUM_W-2:0], div_ge};
  assign div_last     = (div_cnt == 4'(sdba_pkg::DIV_STEPS - 1));

  // Divider and pending result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_action  <= res_action_next;
      res_tap     <= res_tap_next;
      res_slips   <= res_slips_next;
      res_aligned <= res_aligned_next;
      div_rem     <= '0;
      div_quo     <= sum_n;
      div_dvs     <= cnt_n;
      div_cnt     <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? 7'(div_trial - {1'b0, div_dvs})
                        : div_trial[sdba_pkg::CNT_W-1:0];
      div_quo <= div_quo_step;
      div_cnt <= div_cnt + 4'd1;
      if (div_last) begin
        res_tap <= div_quo_step[sdba_pkg::TAP_W-1:0];
      end
    end
  end

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      action  <= res_action;
      tap     <= res_tap;
      slips   <= res_slips;
      aligned <= res_aligned;
    end
  end

endmodule

// ===== hdl/serdes_delay_bitslip_align.sv =====
// Channel  Dir  Payload                          Handshake
// req      in   kind, readback_word              valid/ready
// rsp      out  action, tap, slips, aligned      valid/ready
// cfg      in   cfg_index, cfg_data              cfg_we, no wait
//
// An item that gives a result is accepted, then loaded into the output register once that register is free.
// The readback that ends the scan with passing taps also runs the restoring
// divider for the tap average, which produces one quotient bit per cycle of its 12-bit quotient.
// A readback while idle gives no result.
// rst is synchronous; there is no clearing pass, the block takes items right after reset.
// req.ready drops while an item is in work; a held result waits in the output register.
module serdes_delay_bitslip_align (
  input  logic                           clk,
  input  logic                           rst,
  sdba_req_if.sink                       req,
  sdba_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [sdba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdba_pkg::WORD_W-1:0]    cfg_data
);

  sdba_pkg::sdba_cmd_t cmd;
  sdba_pkg::sdba_sts_t sts;

  // Sequencer
  sdba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Scan, average and alignment datapath
  sdba_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (req.kind),
    .readback_word (req.readback_word),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .action        (rsp.action),
    .tap           (rsp.tap),
    .slips         (rsp.slips),
    .aligned       (rsp.aligned),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
